// ===== src/imdc_pkg.sv =====
// Shared types, widths and codes for the IMU motion direction classifier.
`default_nettype none
package imdc_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int RAW_W      = 16;
	localparam int AXIS_W     = RAW_W + FRAC_BITS;
	localparam int DIFF_W     = AXIS_W + 1;
	localparam int ALPHA_W    = 9;
	localparam int ALPHA_FRAC = 8;
	localparam int PROD_W     = DIFF_W + ALPHA_W + 1;
	localparam int SQ_W       = 2 * AXIS_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int STAB_W     = 32;
	localparam int MOTION_W   = 34;
	localparam int THR_W      = 16;
	localparam int THR_SQ_W   = 2 * THR_W;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_AXES   = 3;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1 << ALPHA_FRAC);
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(51);
	localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(164);

	typedef enum logic {
		REG_ALPHA     = 1'b0,
		REG_THRESHOLD = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		DIR_STILL   = 3'd0,
		DIR_RIGHT   = 3'd1,
		DIR_LEFT    = 3'd2,
		DIR_FORWARD = 3'd3,
		DIR_BACK    = 3'd4,
		DIR_UP      = 3'd5,
		DIR_DOWN    = 3'd6
	} dir_t;

	typedef struct packed {
		logic signed [RAW_W-1:0] accel_x;
		logic signed [RAW_W-1:0] accel_y;
		logic signed [RAW_W-1:0] accel_z;
	} in_item_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] smooth_x;
		logic signed [AXIS_W-1:0] smooth_y;
		logic signed [AXIS_W-1:0] smooth_z;
		logic [STAB_W-1:0]        stability;
		logic [MOTION_W-1:0]      motion_squared;
		dir_t                     direction;
	} out_item_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_s3;
	} lane_ctrl_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] smooth;
		logic [SQ_W-1:0]          sq_smooth;
		logic [SQ_W-1:0]          sq_delta;
		logic [AXIS_W-1:0]        mag_delta;
		logic                     pos;
	} lane_res_t;

endpackage
`default_nettype wire

// ===== src/imdc_lane.sv =====
// One axis lane: exponential moving-average filter, delta, and squares of both.
`default_nettype none
module imdc_lane (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire imdc_pkg::lane_ctrl_t                ctrl,
	input  wire logic [imdc_pkg::ALPHA_W-1:0]        alpha,
	input  wire logic signed [imdc_pkg::RAW_W-1:0]   sample,
	output imdc_pkg::lane_res_t                      res
);

	logic signed [imdc_pkg::AXIS_W-1:0] filt_q;
	logic signed [imdc_pkg::AXIS_W-1:0] target;
	logic signed [imdc_pkg::DIFF_W-1:0] diff;
	logic signed [imdc_pkg::ALPHA_W:0]  alpha_s;
	logic signed [imdc_pkg::PROD_W-1:0] prod_s1;
	logic signed [imdc_pkg::PROD_W-1:0] prod_shr;
	logic signed [imdc_pkg::DIFF_W-1:0] step;
	logic signed [imdc_pkg::DIFF_W-1:0] new_sum;
	logic signed [imdc_pkg::DIFF_W-1:0] step_s2;
	logic signed [imdc_pkg::DIFF_W-1:0] step_neg;
	logic [imdc_pkg::AXIS_W-1:0]        mag_delta;
	logic [imdc_pkg::AXIS_W-1:0]        mag_smooth;
	logic [imdc_pkg::SQ_W-1:0]          sq_smooth_s3;
	logic [imdc_pkg::SQ_W-1:0]          sq_delta_s3;
	logic [imdc_pkg::AXIS_W-1:0]        mag_delta_s3;
	logic                               pos_s3;

	assign target  = {sample, {imdc_pkg::FRAC_BITS{1'b0}}};
	assign diff    = imdc_pkg::DIFF_W'(target) - imdc_pkg::DIFF_W'(filt_q);
	assign alpha_s = $signed({1'b0, alpha});

	// floor of the weighted difference: arithmetic shift rounds toward minus infinity
	assign prod_shr = prod_s1 >>> imdc_pkg::ALPHA_FRAC;
	assign step     = prod_shr[imdc_pkg::DIFF_W-1:0];
	assign new_sum  = imdc_pkg::DIFF_W'(filt_q) + step;

	assign step_neg   = -step_s2;
	assign mag_delta  = step_s2[imdc_pkg::DIFF_W-1] ? step_neg[imdc_pkg::AXIS_W-1:0]
		: step_s2[imdc_pkg::AXIS_W-1:0];
	assign mag_smooth = filt_q[imdc_pkg::AXIS_W-1] ? imdc_pkg::AXIS_W'(-filt_q)
		: imdc_pkg::AXIS_W'(filt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (ctrl.load_s2) begin
			filt_q <= new_sum[imdc_pkg::AXIS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s1) begin
			prod_s1 <= imdc_pkg::PROD_W'(diff) * imdc_pkg::PROD_W'(alpha_s);
		end
		if (ctrl.load_s2) begin
			step_s2 <= step;
		end
		if (ctrl.load_s3) begin
			sq_smooth_s3 <= imdc_pkg::SQ_W'(mag_smooth) * imdc_pkg::SQ_W'(mag_smooth);
			sq_delta_s3  <= imdc_pkg::SQ_W'(mag_delta) * imdc_pkg::SQ_W'(mag_delta);
			mag_delta_s3 <= mag_delta;
			pos_s3       <= !step_s2[imdc_pkg::DIFF_W-1] && (step_s2 != '0);
		end
	end

	assign res.smooth    = filt_q;
	assign res.sq_smooth = sq_smooth_s3;
	assign res.sq_delta  = sq_delta_s3;
	assign res.mag_delta = mag_delta_s3;
	assign res.pos       = pos_s3;

endmodule
`default_nettype wire

// ===== src/imdc_merge.sv =====
// Merge of the three lanes: sums of squares, threshold test and direction pick.
`default_nettype none
module imdc_merge (
	input  wire imdc_pkg::lane_res_t                lanes [imdc_pkg::NUM_AXES],
	input  wire logic [imdc_pkg::THR_SQ_W-1:0]      thr_sq,
	output imdc_pkg::out_item_t                     result
);

	logic [imdc_pkg::SUM_W-1:0] sum_smooth;
	logic [imdc_pkg::SUM_W-1:0] sum_delta;
	logic [imdc_pkg::SUM_W-1:0] thr_scaled;
	logic                       moving;
	logic [imdc_pkg::AXIS_W-1:0] ax, ay, az;

	assign sum_smooth = imdc_pkg::SUM_W'(lanes[0].sq_smooth)
		+ imdc_pkg::SUM_W'(lanes[1].sq_smooth) + imdc_pkg::SUM_W'(lanes[2].sq_smooth);
	assign sum_delta  = imdc_pkg::SUM_W'(lanes[0].sq_delta)
		+ imdc_pkg::SUM_W'(lanes[1].sq_delta) + imdc_pkg::SUM_W'(lanes[2].sq_delta);

	// compare against the threshold squared with the fraction still present
	assign thr_scaled = imdc_pkg::SUM_W'(thr_sq) << (2 * imdc_pkg::FRAC_BITS);
	assign moving     = sum_delta > thr_scaled;

	assign ax = lanes[0].mag_delta;
	assign ay = lanes[1].mag_delta;
	assign az = lanes[2].mag_delta;

	always_comb begin
		result.smooth_x       = lanes[0].smooth;
		result.smooth_y       = lanes[1].smooth;
		result.smooth_z       = lanes[2].smooth;
		result.stability      = sum_smooth[2*imdc_pkg::FRAC_BITS +: imdc_pkg::STAB_W];
		result.motion_squared = sum_delta[2*imdc_pkg::FRAC_BITS +: imdc_pkg::MOTION_W];
		result.direction      = imdc_pkg::DIR_STILL;
		if (moving) begin
			// Z takes all ties
			if (ax > ay && ax > az) begin
				result.direction = lanes[0].pos ? imdc_pkg::DIR_RIGHT : imdc_pkg::DIR_LEFT;
			end else if (ay > ax && ay > az) begin
				result.direction = lanes[1].pos ? imdc_pkg::DIR_FORWARD : imdc_pkg::DIR_BACK;
			end else begin
				result.direction = lanes[2].pos ? imdc_pkg::DIR_UP : imdc_pkg::DIR_DOWN;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/imu_motion_direction_classifier.sv =====
// Top level of the IMU motion direction classifier: control, config and output register.
`default_nettype none
// Takes one three-axis accelerometer word at a time and returns one result word per
// input: the exponential moving-average smoothed axes (Q16.8), the stability sum of squares, the
// squared motion magnitude and a direction code. Three axis lanes run side by side
// through a filter multiply stage, a state update stage and a squaring stage, then a
// merge stage loads the output register; a finished result waits in the squaring stage while
// the output register is full, and the next input is taken once the current result is in
// the output register, so no new word is accepted before the last one has left the lane
// stages. The filter state of one word must be written back before the next word may read
// it. Configuration: index 0 is the smoothing weight (Q1.8, values above 256 act as 256),
// index 1 the motion threshold in raw counts; write them only while idle.
module imu_motion_direction_classifier (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire imdc_pkg::cfg_reg_t                cfg_index,
	input  wire logic [imdc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire imdc_pkg::in_item_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output imdc_pkg::out_item_t                    out_data
);

	logic [imdc_pkg::ALPHA_W-1:0]  alpha_q;
	logic [imdc_pkg::ALPHA_W-1:0]  alpha_sat;
	logic [imdc_pkg::THR_W-1:0]    thr_q;
	logic [imdc_pkg::THR_SQ_W-1:0] thr_sq_q;
	logic                          busy_q;
	logic                          v1_q, v2_q, v3_q;
	logic                          out_valid_q;
	imdc_pkg::out_item_t           out_data_q;
	logic                          accept;
	logic                          advance;
	imdc_pkg::lane_ctrl_t          ctrl;
	imdc_pkg::lane_res_t           lanes [imdc_pkg::NUM_AXES];
	logic signed [imdc_pkg::RAW_W-1:0] samples [imdc_pkg::NUM_AXES];
	imdc_pkg::out_item_t           merged;

	assign in_ready  = !busy_q;
	assign accept    = in_valid && in_ready;
	// hold the finished word in stage 3 until the output register is free
	assign advance   = v3_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign alpha_sat = (alpha_q > imdc_pkg::ALPHA_ONE) ? imdc_pkg::ALPHA_ONE : alpha_q;

	assign ctrl.load_s1 = accept;
	assign ctrl.load_s2 = v1_q;
	assign ctrl.load_s3 = v2_q;

	assign samples[0] = in_data.accel_x;
	assign samples[1] = in_data.accel_y;
	assign samples[2] = in_data.accel_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= imdc_pkg::ALPHA_RESET;
			thr_q   <= imdc_pkg::THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				imdc_pkg::REG_ALPHA:     alpha_q <= cfg_data[imdc_pkg::ALPHA_W-1:0];
				imdc_pkg::REG_THRESHOLD: thr_q   <= cfg_data[imdc_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		thr_sq_q <= imdc_pkg::THR_SQ_W'(thr_q) * imdc_pkg::THR_SQ_W'(thr_q);
		if (advance) begin
			out_data_q <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v1_q        <= accept;
			v2_q        <= v1_q;
			v3_q        <= v2_q || (v3_q && !advance);
			busy_q      <= accept || (busy_q && !advance);
			out_valid_q <= advance || (out_valid_q && !out_ready);
		end
	end

	for (genvar i = 0; i < imdc_pkg::NUM_AXES; i++) begin : g_lane
		imdc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.alpha  (alpha_sat),
			.sample (samples[i]),
			.res    (lanes[i])
		);
	end

	imdc_merge u_merge (
		.lanes  (lanes),
		.thr_sq (thr_sq_q),
		.result (merged)
	);

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v1_q, v2_q, v3_q}))
		else $error("more than one word in the lane pipeline");

	a_stages_need_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q || v2_q || v3_q) |-> busy_q)
		else $error("pipeline stage active while block idle");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (!in_ready && v1_q))
		else $error("accepted word did not enter stage 1");

	a_motion_over_thr: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (merged.direction != imdc_pkg::DIR_STILL)
		|-> (imdc_pkg::SUM_W'(merged.motion_squared) >= imdc_pkg::SUM_W'(thr_sq_q)))
		else $error("direction reported below motion threshold");
`endif

endmodule
`default_nettype wire

// ===== tb/imu_motion_direction_classifier_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the IMU motion direction classifier: directed and random words.
module imu_motion_direction_classifier_test;
	import imdc_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD  = 300;
	localparam int SETTLE     = 12;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	cfg_reg_t              cfg_index = REG_ALPHA;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;

	imu_motion_direction_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	// predictor copy of the block's registers and filter state
	logic [ALPHA_W-1:0] alpha_setting     = ALPHA_RESET;
	logic [THR_W-1:0]   threshold_setting = THR_RESET;
	longint             smoothed_axes[NUM_AXES] = '{0, 0, 0};

	in_item_t  pending_samples[$];
	out_item_t expected_results[$];
	in_item_t  last_sample = '0;

	int mismatches   = 0;
	int results_seen = 0;
	int send_gap     = 0;
	int send_burst   = 0;
	int recv_stall   = 0;
	int recv_burst   = 0;
	int idle_cycles  = 0;
	bit held_long    = 1'b0;

	function automatic out_item_t filter_and_classify(in_item_t w);
		longint    raw[NUM_AXES];
		longint    delta[NUM_AXES];
		longint    mag[NUM_AXES];
		longint    wgt;
		longint    target;
		longint    step;
		longint    stab_sum;
		longint    motion_sum;
		longint    thr_sq;
		out_item_t r;
		raw[0] = longint'(w.accel_x);
		raw[1] = longint'(w.accel_y);
		raw[2] = longint'(w.accel_z);
		wgt = (alpha_setting > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_setting);
		stab_sum = 0;
		motion_sum = 0;
		for (int i = 0; i < NUM_AXES; i++) begin
			target = raw[i] <<< FRAC_BITS;
			// arithmetic shift floors toward minus infinity
			step = ((target - smoothed_axes[i]) * wgt) >>> ALPHA_FRAC;
			smoothed_axes[i] += step;
			delta[i] = step;
			mag[i] = (step < 0) ? -step : step;
			stab_sum += smoothed_axes[i] * smoothed_axes[i];
			motion_sum += step * step;
		end
		r.smooth_x = AXIS_W'(smoothed_axes[0]);
		r.smooth_y = AXIS_W'(smoothed_axes[1]);
		r.smooth_z = AXIS_W'(smoothed_axes[2]);
		r.stability = STAB_W'(stab_sum >> (2 * FRAC_BITS));
		r.motion_squared = MOTION_W'(motion_sum >> (2 * FRAC_BITS));
		thr_sq = longint'(threshold_setting) * longint'(threshold_setting);
		r.direction = DIR_STILL;
		// compare the exact sum, fraction included, against the scaled square
		if (motion_sum > (thr_sq <<< (2 * FRAC_BITS))) begin
			if (mag[0] > mag[1] && mag[0] > mag[2])
				r.direction = (delta[0] > 0) ? DIR_RIGHT : DIR_LEFT;
			else if (mag[1] > mag[0] && mag[1] > mag[2])
				r.direction = (delta[1] > 0) ? DIR_FORWARD : DIR_BACK;
			else
				r.direction = (delta[2] > 0) ? DIR_UP : DIR_DOWN;
		end
		return r;
	endfunction

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t random_sample(in_item_t prev);
		logic signed [RAW_W-1:0] p[NUM_AXES];
		logic signed [RAW_W-1:0] a[NUM_AXES];
		int                      kind;
		in_item_t                s;
		p[0] = prev.accel_x;
		p[1] = prev.accel_y;
		p[2] = prev.accel_z;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < NUM_AXES; i++) begin
			case (kind)
				0, 1, 2, 3: a[i] = RAW_W'($urandom);
				4, 5: a[i] = p[i] + RAW_W'(int'($urandom_range(0, 1200)) - 600);
				6, 7: a[i] = p[i] + RAW_W'(int'($urandom_range(0, 12000)) - 6000);
				8: begin
					case ($urandom_range(0, 3))
						0: a[i] = 16'sh7fff;
						1: a[i] = 16'sh8000;
						2: a[i] = 16'sh0000;
						default: a[i] = 16'shffff;
					endcase
				end
				default: a[i] = p[i];
			endcase
		end
		s.accel_x = a[0];
		s.accel_y = a[1];
		s.accel_z = a[2];
		return s;
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		results_seen++;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result word with nothing expected: %h", $time, got);
			return;
		end
		want = expected_results.pop_front();
		compare_field("smooth_x", want.smooth_x, got.smooth_x);
		compare_field("smooth_y", want.smooth_y, got.smooth_y);
		compare_field("smooth_z", want.smooth_z, got.smooth_z);
		compare_field("stability", want.stability, got.stability);
		compare_field("motion_squared", want.motion_squared, got.motion_squared);
		compare_field("direction", want.direction, got.direction);
	endtask

	// sender: present queued words, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(filter_and_classify(in_data));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_samples.pop_front();
					if (send_burst > 0) begin
						send_burst--;
						send_gap = 0;
					end else begin
						send_gap = gap_length();
						if ($urandom_range(0, 39) == 0)
							send_burst = $urandom_range(20, 80);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each accepted word, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_result(out_data);
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else if (!held_long && results_seen >= 150) begin
				// hold off long enough for the block to back up into its input
				held_long = 1'b1;
				recv_stall = LONG_HOLD;
				out_ready <= 1'b0;
			end else if (recv_burst > 0) begin
				recv_burst--;
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 39) == 0) begin
				recv_burst = $urandom_range(20, 80);
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 70) begin
				out_ready <= 1'b1;
			end else begin
				recv_stall = gap_length();
				out_ready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("imu_motion_direction_classifier_test: FAIL");
				$finish;
			end
		end
	end

	task automatic push_sample(int x, int y, int z);
		in_item_t s;
		s.accel_x = RAW_W'(x);
		s.accel_y = RAW_W'(y);
		s.accel_z = RAW_W'(z);
		pending_samples.push_back(s);
		last_sample = s;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] alpha_word, logic [CFG_DATA_W-1:0] thr_word);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ALPHA;
		cfg_data <= alpha_word;
		alpha_setting = alpha_word[ALPHA_W-1:0];
		@(posedge clk);
		cfg_index <= REG_THRESHOLD;
		cfg_data <= thr_word;
		threshold_setting = thr_word;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			last_sample = random_sample(last_sample);
			pending_samples.push_back(last_sample);
		end
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, full-scale swings
		push_sample(32767, -32768, 0);
		push_sample(-32768, 32767, -1);
		push_sample(0, 0, 0);
		push_sample(32767, 32767, 32767);
		push_sample(-32768, -32768, -32768);
		push_sample(1, -1, 0);
		wait_drained();

		// no smoothing, upper data bits set; every direction and the tie rules
		configure(16'hFE00 | 16'd256, 16'd5);
		push_sample(0, 0, 0);
		push_sample(0, 0, 0);
		push_sample(3, 4, 0);
		push_sample(6, 8, 1);
		push_sample(100, 0, 0);
		push_sample(0, 0, 0);
		push_sample(0, 50, 0);
		push_sample(0, 0, 0);
		push_sample(0, 0, 50);
		push_sample(0, 0, 0);
		push_sample(20, 20, 0);
		push_sample(0, 0, 0);
		push_sample(10, 10, 10);
		wait_drained();

		// frozen filter, zero threshold
		configure(16'd0, 16'd0);
		push_sample(32767, -32768, 12345);
		push_sample(-1, -1, -1);
		wait_drained();

		// weight above one saturates; largest threshold
		configure(16'd511, 16'hFFFF);
		push_sample(32767, 32767, 32767);
		push_sample(-32768, -32768, -32768);
		push_sample(0, 0, 0);
		wait_drained();

		configure(16'(ALPHA_RESET), 16'(THR_RESET));
		run_random(100);
		configure(16'($urandom_range(1, 255)), 16'($urandom_range(0, 400)));
		run_random(100);
		configure(16'd256, 16'($urandom_range(0, 2000)));
		run_random(100);
		configure({7'($urandom_range(0, 127)), 9'($urandom_range(257, 511))}, 16'($urandom));
		run_random(100);
		configure(16'd0, 16'd0);
		run_random(100);
		configure(16'($urandom_range(0, 511)), 16'hFFFF);
		run_random(100);
		configure(16'($urandom_range(16, 128)), 16'($urandom_range(0, 100)));
		run_random(100);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("imu_motion_direction_classifier_test: PASS");
		else
			$display("imu_motion_direction_classifier_test: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/imdc_pkg.sv
src/imdc_lane.sv
src/imdc_merge.sv
src/imu_motion_direction_classifier.sv
tb/imu_motion_direction_classifier_test.sv
